// ----- rtl/core/dma2d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma2d_pkg: shared types and constants
// Payload structs, descriptor layout, command and mode codes, controller
// states and the control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dma2d_pkg;

    // field widths fixed by the channel payloads
    localparam int ADDRESS_BITS = 16;
    localparam int COUNT_BITS   = 16;
    localparam int DATA_BITS    = 32;
    localparam int ENTRY_BITS   = 4;

    // default descriptor table depth
    localparam int DESCRIPTOR_DEPTH_DEF = 16;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // descriptor modes
    localparam logic [1:0] MODE_SUSPENDED = 2'd0;
    localparam logic [1:0] MODE_TRANSFER  = 2'd1;
    localparam logic [1:0] MODE_WAIT      = 2'd2;

    // direction register values
    localparam logic DIR_MEM_TO_STREAM = 1'b0;
    localparam logic DIR_STREAM_TO_MEM = 1'b1;

    // incoming request
    typedef struct packed {
        logic [1:0]              command;
        logic [DATA_BITS-1:0]    stream_data;
        logic [ENTRY_BITS-1:0]   entry_index;
        logic [ENTRY_BITS-1:0]   next_entry;
        logic [ADDRESS_BITS-1:0] start_address;
        logic [1:0]              entry_mode;
        logic [COUNT_BITS-1:0]   row_length;
        logic [ADDRESS_BITS-1:0] element_stride;
        logic [COUNT_BITS-1:0]   extra_rows;
        logic [ADDRESS_BITS-1:0] row_stride;
    } cmd_item_t;

    // outgoing result
    typedef struct packed {
        logic                    access_valid;
        logic                    access_write;
        logic [ADDRESS_BITS-1:0] access_address;
        logic [DATA_BITS-1:0]    write_word;
        logic                    stream_clear;
        logic                    descriptor_done;
        logic [ENTRY_BITS-1:0]   active_entry;
    } result_t;

    // one descriptor table entry
    typedef struct packed {
        logic [ENTRY_BITS-1:0]   next_entry;
        logic [ADDRESS_BITS-1:0] start_address;
        logic [1:0]              mode;
        logic [COUNT_BITS-1:0]   x_count;
        logic [ADDRESS_BITS-1:0] x_step;
        logic [COUNT_BITS-1:0]   y_count;
        logic [ADDRESS_BITS-1:0] y_step;
    } desc_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_RELOAD_RD,
        ST_RELOAD_SET,
        ST_PUSH
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic fetch;
        logic exec;
        logic reload_set;
        logic push;
    } dp_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] command;
        logic       tick_done;
        logic       out_free;
    } dp_stat_t;

endpackage

// ----- rtl/core/dma2d_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma2d_ctrl: request sequencer
// Walks each request through capture, descriptor fetch, execute, optional
// counter reload from a new descriptor, and hand-off to the output register.
// ----------------------------------------------------------------------------
module dma2d_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  dma2d_pkg::dp_stat_t stat,
    output dma2d_pkg::dp_ctrl_t ctrl,
    output logic                cmd_stall
);

    dma2d_pkg::ctrl_state_t state_reg;
    dma2d_pkg::ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dma2d_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next      = state_reg;
        ctrl            = '0;
        cmd_stall       = 1'b1;
        case (state_reg)
            dma2d_pkg::ST_IDLE:
            begin
                cmd_stall    = 1'b0;
                ctrl.capture = cmd_valid;
                if (cmd_valid)
                begin
                    state_next = dma2d_pkg::ST_FETCH;
                end
            end
            dma2d_pkg::ST_FETCH:
            begin
                ctrl.fetch = 1'b1;
                state_next = dma2d_pkg::ST_EXEC;
            end
            dma2d_pkg::ST_EXEC:
            begin
                ctrl.exec = 1'b1;
                if (stat.command == dma2d_pkg::CMD_START ||
                    (stat.command == dma2d_pkg::CMD_TICK && stat.tick_done))
                begin
                    state_next = dma2d_pkg::ST_RELOAD_RD;
                end
                else
                begin
                    state_next = dma2d_pkg::ST_PUSH;
                end
            end
            dma2d_pkg::ST_RELOAD_RD:
            begin
                ctrl.fetch = 1'b1;
                state_next = dma2d_pkg::ST_RELOAD_SET;
            end
            dma2d_pkg::ST_RELOAD_SET:
            begin
                ctrl.reload_set = 1'b1;
                state_next      = dma2d_pkg::ST_PUSH;
            end
            dma2d_pkg::ST_PUSH:
            begin
                ctrl.push = 1'b1;
                if (stat.out_free)
                begin
                    state_next = dma2d_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dma2d_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/dma2d_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma2d_datapath: descriptor table, counters and output register
// Holds the descriptor memory, the executing entry, the word address and the
// row/tick counters, forms each result and keeps it until it is taken.
// ----------------------------------------------------------------------------
module dma2d_datapath
#(
    parameter int DESCRIPTOR_DEPTH = dma2d_pkg::DESCRIPTOR_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dma2d_pkg::dp_ctrl_t  ctrl,
    output dma2d_pkg::dp_stat_t  stat,
    input  dma2d_pkg::cmd_item_t cmd_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic                 cfg_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output dma2d_pkg::result_t   res_data
);

    localparam int IDX_W = (DESCRIPTOR_DEPTH > 1) ? $clog2(DESCRIPTOR_DEPTH) : 1;

    // descriptor memory, no reset
    dma2d_pkg::desc_t mem [DESCRIPTOR_DEPTH];

    dma2d_pkg::cmd_item_t item_reg;
    dma2d_pkg::desc_t     rdata_reg;
    logic                 rzero_reg;
    logic                 dir_reg;
    logic                 dir_next;
    logic                 init0_reg;
    logic                 init0_next;
    logic [dma2d_pkg::ENTRY_BITS-1:0]   entry_reg;
    logic [dma2d_pkg::ENTRY_BITS-1:0]   entry_next;
    logic [dma2d_pkg::ADDRESS_BITS-1:0] addr_reg;
    logic [dma2d_pkg::ADDRESS_BITS-1:0] addr_next;
    logic [dma2d_pkg::COUNT_BITS-1:0]   ticks_reg;
    logic [dma2d_pkg::COUNT_BITS-1:0]   ticks_next;
    logic [dma2d_pkg::COUNT_BITS-1:0]   rows_reg;
    logic [dma2d_pkg::COUNT_BITS-1:0]   rows_next;
    dma2d_pkg::result_t   res_reg;
    dma2d_pkg::result_t   res_next;
    dma2d_pkg::result_t   out_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    dma2d_pkg::desc_t     cur;
    dma2d_pkg::desc_t     wdesc;
    logic                 is_active;
    logic                 reload;
    logic                 wr_hit;
    logic [IDX_W-1:0]     ridx;
    logic [IDX_W-1:0]     widx;
    logic [dma2d_pkg::COUNT_BITS-1:0]   ticks_dec;
    logic [dma2d_pkg::COUNT_BITS-1:0]   ticks_upd;
    logic [dma2d_pkg::COUNT_BITS-1:0]   rows_upd;
    logic [dma2d_pkg::ADDRESS_BITS-1:0] addr_step;
    logic [dma2d_pkg::ADDRESS_BITS-1:0] addr_upd;
    logic                 tick_done;
    logic                 out_free;

    // descriptor seen by the sequencer: unwritten entry 0 and entries past
    // the table read as a suspended all-zero descriptor
    assign cur = rzero_reg ? '0 : rdata_reg;

    assign ridx  = IDX_W'(entry_reg);
    assign widx  = IDX_W'(item_reg.entry_index);
    assign wr_hit = ctrl.exec && (item_reg.command == dma2d_pkg::CMD_WRITE) &&
                    (int'(item_reg.entry_index) < DESCRIPTOR_DEPTH);

    // descriptor built from a write request
    always_comb
    begin
        wdesc.next_entry    = item_reg.next_entry;
        wdesc.start_address = item_reg.start_address;
        wdesc.mode          = item_reg.entry_mode;
        wdesc.x_count       = item_reg.row_length;
        wdesc.x_step        = item_reg.element_stride;
        wdesc.y_count       = item_reg.extra_rows;
        wdesc.y_step        = item_reg.row_stride;
    end

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[widx] <= wdesc;
        end
        if (ctrl.fetch)
        begin
            rdata_reg <= mem[ridx];
            rzero_reg <= (int'(entry_reg) >= DESCRIPTOR_DEPTH) ||
                         ((entry_reg == '0) && !init0_reg);
        end
    end

    // request capture, result register and output register
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            item_reg <= cmd_data;
        end
        if (ctrl.exec)
        begin
            res_reg <= res_next;
        end
        if (ctrl.push && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    // tick arithmetic: one tick decrement, one row decrement, one address add
    always_comb
    begin
        is_active = (cur.mode == dma2d_pkg::MODE_TRANSFER) ||
                    (cur.mode == dma2d_pkg::MODE_WAIT);
        ticks_dec = ticks_reg - 1'b1;
        reload    = (ticks_dec == '0) && (rows_reg != '0);
        ticks_upd = reload ? cur.x_count : ticks_dec;
        rows_upd  = reload ? rows_reg - 1'b1 : rows_reg;
        addr_step = reload ? cur.y_step : cur.x_step;
        addr_upd  = ((ticks_dec == '0) && !reload) ? addr_reg : addr_reg + addr_step;
        tick_done = is_active && (ticks_upd == '0) && (rows_upd == '0);
    end

    // next state of counters and result
    always_comb
    begin
        dir_next       = dir_reg;
        init0_next     = init0_reg;
        entry_next     = entry_reg;
        addr_next      = addr_reg;
        ticks_next     = ticks_reg;
        rows_next      = rows_reg;
        res_next       = '0;
        out_valid_next = out_valid_reg;

        if (cfg_valid && cfg_ready)
        begin
            dir_next = cfg_data;
        end

        if (ctrl.exec)
        begin
            case (item_reg.command)
                dma2d_pkg::CMD_TICK:
                begin
                    if (is_active)
                    begin
                        ticks_next = ticks_upd;
                        rows_next  = rows_upd;
                        addr_next  = addr_upd;
                        if (cur.mode == dma2d_pkg::MODE_TRANSFER)
                        begin
                            res_next.access_valid   = 1'b1;
                            res_next.access_write   = dir_reg;
                            res_next.access_address = addr_reg;
                            if (dir_reg == dma2d_pkg::DIR_STREAM_TO_MEM)
                            begin
                                res_next.write_word = item_reg.stream_data;
                            end
                        end
                        if (tick_done)
                        begin
                            entry_next               = cur.next_entry;
                            res_next.descriptor_done = 1'b1;
                        end
                    end
                    else if (dir_reg == dma2d_pkg::DIR_MEM_TO_STREAM)
                    begin
                        res_next.stream_clear = 1'b1;
                    end
                end
                dma2d_pkg::CMD_WRITE:
                begin
                    if (wr_hit && (item_reg.entry_index == '0))
                    begin
                        init0_next = 1'b1;
                    end
                end
                dma2d_pkg::CMD_START:
                begin
                    entry_next = '0;
                end
                default:
                begin
                    entry_next = entry_reg;
                end
            endcase
            res_next.active_entry = entry_next;
        end

        // counters reload from the newly selected descriptor
        if (ctrl.reload_set)
        begin
            addr_next  = cur.start_address;
            ticks_next = cur.x_count;
            rows_next  = cur.y_count;
        end

        // output register
        if (ctrl.push && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= dma2d_pkg::DIR_MEM_TO_STREAM;
            init0_reg     <= 1'b0;
            entry_reg     <= '0;
            addr_reg      <= '0;
            ticks_reg     <= '0;
            rows_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dir_reg       <= dir_next;
            init0_reg     <= init0_next;
            entry_reg     <= entry_next;
            addr_reg      <= addr_next;
            ticks_reg     <= ticks_next;
            rows_reg      <= rows_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free       = !out_valid_reg || !res_stall;
    assign res_valid      = out_valid_reg;
    assign res_data       = out_reg;
    assign stat.command   = item_reg.command;
    assign stat.tick_done = tick_done;
    assign stat.out_free  = out_free;

`ifndef ASSERT_OFF
    // execute always works on freshly fetched descriptor data
    a_exec_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec |-> $past(ctrl.fetch))
        else $error("execute without descriptor fetch");

    // counter reload uses the descriptor read in the previous cycle
    a_reload_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.reload_set |-> $past(ctrl.fetch))
        else $error("counter reload without descriptor fetch");

    // a push into a free output slot shows a result next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.push && out_free) |=> out_valid_reg)
        else $error("pushed result did not reach output register");

    // a finished descriptor reports the entry it chained to
    a_done_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.exec && item_reg.command == dma2d_pkg::CMD_TICK && tick_done)
        |=> (res_reg.descriptor_done && res_reg.active_entry == entry_reg))
        else $error("descriptor done result does not match executing entry");
`endif

endmodule

// ----- rtl/core/descriptor_chain_dma_2d.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_chain_dma_2d: descriptor-chained 2D DMA address sequencer
// Usage:
//   cmd channel (cmd_valid, cmd_stall, cmd_data) takes one request: a tick,
//   a descriptor table write, or a start at entry 0.
//   res channel (res_valid, res_stall, res_data) returns exactly one result
//   per request: access flags, address, write word, stream clear, descriptor
//   done and the entry executing afterwards.
//   cfg channel (cfg_valid, cfg_ready, cfg_data) writes the direction bit;
//   cfg_ready is always high, write it only while the block is idle.
// Steps: a request is captured, its descriptor read from the table, then
//   executed and handed to the output register; when a descriptor finishes
//   or a start reloads the counters, the table read of the new entry and the
//   counter load come between execute and the output register.
// Requests: one at a time; the next is taken the cycle after the result
//   moves into the output register.
// Reset: direction memory-to-stream, entry 0 suspended, counters zero.
// Stall: a held result keeps res_data stable; a new request may be taken
//   meanwhile but its result waits until the output register frees up.
// ----------------------------------------------------------------------------
module descriptor_chain_dma_2d
#(
    parameter int DESCRIPTOR_DEPTH = dma2d_pkg::DESCRIPTOR_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  dma2d_pkg::cmd_item_t cmd_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output dma2d_pkg::result_t   res_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    dma2d_pkg::dp_ctrl_t ctrl;
    dma2d_pkg::dp_stat_t stat;

    // direction register takes every write
    assign cfg_ready = 1'b1;

    // sequencer
    dma2d_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .stat      (stat),
        .ctrl      (ctrl),
        .cmd_stall (cmd_stall)
    );

    // table, counters and output register
    dma2d_datapath
    #(
        .DESCRIPTOR_DEPTH (DESCRIPTOR_DEPTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .cmd_data  (cmd_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
